[rtl/bss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bss_pkg;

    // Defaults for the top-level parameters
    localparam int AGENTS_DEF     = 128;
    localparam int COUNT_BITS_DEF = 48;

    // Register map
    localparam logic       REG_LIST_FACTOR = 1'b0;
    localparam logic [4:0] LIST_FACTOR_RST = 5'd5;

    // Opcodes
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_STEP = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [6:0]  agent_index;
        logic [31:0] middle_value;
        logic [31:0] left_value;
        logic [31:0] right_value;
    } in_word_t;

    typedef struct packed {
        logic [6:0]  min_agent;
        logic [6:0]  left_rank;
        logic [6:0]  right_rank;
        logic        rebuilt;
        logic [7:0]  list_count;
        logic [47:0] counter_value;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HREAD,
        ST_CHK,
        ST_KEY_RD,
        ST_KEY_WT,
        ST_POS,
        ST_MIN,
        ST_RANK,
        ST_BUMP_RD,
        ST_BUMP_WR,
        ST_REPL,
        ST_MAX,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        PH_REBUILD,
        PH_REPLACE,
        PH_TRIM
    } phase_t;

endpackage

`default_nettype wire

[rtl/bss_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module bss_ram
    import bss_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = AGENTS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/bss_order_cmp.sv]
`timescale 1ns / 1ps
`default_nettype none

module bss_order_cmp
    import bss_pkg::*;
#(
    parameter int AW = 7
) (
    input  wire logic [31:0]   a_fit,
    input  wire logic [AW-1:0] a_idx,
    input  wire logic [31:0]   b_fit,
    input  wire logic [AW-1:0] b_idx,
    output logic               a_first
);

    // Order by fitness, ties by lower index
    assign a_first = (a_fit < b_fit) || ((a_fit == b_fit) && (a_idx < b_idx));

endmodule

`default_nettype wire

[rtl/bak_sneppen_shortlist_step.sv]
`timescale 1ns / 1ps
`default_nettype none

// Bak-Sneppen update engine with a ranked shortlist. One compare unit walks the
// fitness memory one agent per cycle under a small sequencer; a rank pass adds a
// key fetch. A step without rebuild runs about (6 + trims) passes; a rebuild adds
// one key fetch and pass per agent plus one more pass. The histogram and
// shortlist bits clear at reset; every agent must be loaded before the first
// step. list_factor sits at byte address 0 of the APB port.
module bak_sneppen_shortlist_step
    import bss_pkg::*;
#(
    parameter int AGENTS     = AGENTS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_word_t    s_word,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_word_t        m_word,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW   = (AGENTS > 1) ? $clog2(AGENTS) : 1;
    localparam int LW   = $clog2(AGENTS + 1);
    localparam int CMPW = (LW > 8) ? LW : 8;
    localparam logic [AW-1:0] LAST = AW'(AGENTS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // Configuration port
    logic [4:0] list_factor_reg;
    logic       cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready & (paddr[2] == REG_LIST_FACTOR);
    assign prdata = (paddr[2] == REG_LIST_FACTOR) ? {27'd0, list_factor_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            list_factor_reg <= LIST_FACTOR_RST;
        end else if (cfg_we) begin
            list_factor_reg <= pwdata[4:0];
        end
    end

    logic [CMPW-1:0] lf_w, three_k, five_k;
    assign lf_w    = CMPW'(list_factor_reg);
    assign three_k = (lf_w << 1) + lf_w;
    assign five_k  = (lf_w << 2) + lf_w;

    // State
    state_t state_reg, state_next, ret_reg, ret_next;
    phase_t phase_reg, phase_next;
    logic [1:0] rep_sel_reg, rep_sel_next, bsel_reg, bsel_next;
    logic       side_reg, side_next, lflag_reg, lflag_next, rflag_reg, rflag_next;
    logic       rb_reg, rb_next;
    logic [31:0] thr_reg, thr_next;
    logic [LW-1:0] len_reg, len_next;
    logic [AGENTS-1:0] listed_reg, listed_next, hvld_reg, hvld_next;
    logic [AW-1:0] iss_cnt_reg, iss_cnt_next, d_idx_reg, d_idx_next;
    logic       iss_done_reg, iss_done_next, d_vld_reg, d_vld_next;
    logic       any_reg, any_next;
    logic [AW-1:0] cnt_reg, cnt_next;

    // Payload
    in_word_t  in_reg, in_next;
    out_word_t out_reg, out_next;
    logic [31:0] best_fit_reg, best_fit_next, key_fit_reg, key_fit_next;
    logic [AW-1:0] best_idx_reg, best_idx_next, key_idx_reg, key_idx_next;
    logic [AW-1:0] m_reg, m_next, left_reg, left_next, right_reg, right_next;
    logic [AW-1:0] lr_reg, lr_next, rr_reg, rr_next, rb_i_reg, rb_i_next;
    logic [AW-1:0] b_addr_reg, b_addr_next;

    // Memories
    logic          fit_we, fit_re;
    logic [AW-1:0] fit_waddr, fit_raddr;
    logic [31:0]   fit_wdata, fit_rdata;
    logic          hist_we, hist_re;
    logic [AW-1:0] hist_waddr, hist_raddr;
    logic [COUNT_BITS-1:0] hist_wdata, hist_rdata, hist_old;

    bss_ram #(.WIDTH(32), .DEPTH(AGENTS)) u_fit_ram (
        .aclk (aclk), .we (fit_we), .waddr (fit_waddr), .wdata (fit_wdata),
        .re (fit_re), .raddr (fit_raddr), .rdata (fit_rdata)
    );

    bss_ram #(.WIDTH(COUNT_BITS), .DEPTH(AGENTS)) u_hist_ram (
        .aclk (aclk), .we (hist_we), .waddr (hist_waddr), .wdata (hist_wdata),
        .re (hist_re), .raddr (hist_raddr), .rdata (hist_rdata)
    );

    // Shared compare unit, operands picked by pass
    logic [31:0]   ca_fit, cb_fit;
    logic [AW-1:0] ca_idx, cb_idx;
    logic          cmp_first;

    always_comb begin
        ca_fit = fit_rdata;
        ca_idx = d_idx_reg;
        cb_fit = key_fit_reg;
        cb_idx = key_idx_reg;
        if (state_reg == ST_MIN) begin
            cb_fit = best_fit_reg;
            cb_idx = best_idx_reg;
        end else if (state_reg == ST_MAX) begin
            ca_fit = best_fit_reg;
            ca_idx = best_idx_reg;
            cb_fit = fit_rdata;
            cb_idx = d_idx_reg;
        end
    end

    bss_order_cmp #(.AW(AW)) u_cmp (
        .a_fit (ca_fit), .a_idx (ca_idx), .b_fit (cb_fit), .b_idx (cb_idx),
        .a_first (cmp_first)
    );

    logic in_scan, scan_last, in_range, pos_in;
    logic [AW-1:0] s_addr, in_addr, left_c, right_c, rep_agent, cnt_fin;
    logic [31:0]   rep_value;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_RESP);
    assign m_word    = out_reg;
    assign in_scan   = state_reg inside {ST_POS, ST_MIN, ST_RANK, ST_MAX};
    assign scan_last = d_vld_reg && (d_idx_reg == LAST);
    assign s_addr    = AW'(s_word.agent_index);
    assign in_addr   = AW'(in_reg.agent_index);
    assign in_range  = (32'(in_reg.agent_index) < 32'(AGENTS));
    assign hist_old  = hvld_reg[b_addr_reg] ? hist_rdata : '0;

    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        phase_next    = phase_reg;
        rep_sel_next  = rep_sel_reg;
        bsel_next     = bsel_reg;
        side_next     = side_reg;
        lflag_next    = lflag_reg;
        rflag_next    = rflag_reg;
        rb_next       = rb_reg;
        thr_next      = thr_reg;
        len_next      = len_reg;
        listed_next   = listed_reg;
        hvld_next     = hvld_reg;
        iss_cnt_next  = iss_cnt_reg;
        iss_done_next = iss_done_reg;
        d_vld_next    = 1'b0;
        d_idx_next    = d_idx_reg;
        any_next      = any_reg;
        cnt_next      = cnt_reg;
        cnt_fin       = cnt_reg;
        in_next       = in_reg;
        out_next      = out_reg;
        best_fit_next = best_fit_reg;
        best_idx_next = best_idx_reg;
        key_fit_next  = key_fit_reg;
        key_idx_next  = key_idx_reg;
        m_next        = m_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        lr_next       = lr_reg;
        rr_next       = rr_reg;
        rb_i_next     = rb_i_reg;
        b_addr_next   = b_addr_reg;
        fit_we        = 1'b0;
        fit_waddr     = s_addr;
        fit_wdata     = s_word.middle_value;
        fit_re        = 1'b0;
        fit_raddr     = iss_cnt_reg;
        hist_we       = 1'b0;
        hist_waddr    = b_addr_reg;
        hist_wdata    = (hist_old == CNT_MAX) ? hist_old : hist_old + 1'b1;
        hist_re       = 1'b0;
        hist_raddr    = s_addr;
        left_c        = (best_idx_next == '0) ? LAST : best_idx_next - 1'b1;
        right_c       = (best_idx_next == LAST) ? '0 : best_idx_next + 1'b1;
        pos_in        = 1'b0;
        rep_agent     = m_reg;
        rep_value     = in_reg.middle_value;

        // Scan issue: one read per cycle, data on the next cycle
        if (in_scan) begin
            if (!iss_done_reg) begin
                fit_re       = 1'b1;
                d_vld_next   = 1'b1;
                d_idx_next   = iss_cnt_reg;
                iss_cnt_next = iss_cnt_reg + 1'b1;
                if (iss_cnt_reg == LAST) begin
                    iss_done_next = 1'b1;
                end
            end
            if (d_vld_reg) begin
                case (state_reg)
                    ST_MIN: begin
                        if (d_idx_reg == '0 || cmp_first) begin
                            best_fit_next = fit_rdata;
                            best_idx_next = d_idx_reg;
                        end
                    end
                    ST_MAX: begin
                        if (listed_reg[d_idx_reg] && (!any_reg || cmp_first)) begin
                            best_fit_next = fit_rdata;
                            best_idx_next = d_idx_reg;
                            any_next      = 1'b1;
                        end
                    end
                    ST_RANK: begin
                        if (listed_reg[d_idx_reg] && cmp_first) begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    default: begin
                        if (cmp_first) begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                endcase
            end
            // count of the whole pass, kept before the clear below
            cnt_fin = cnt_next;
            // recompute neighbors from final minimum
            left_c  = (best_idx_next == '0) ? LAST : best_idx_next - 1'b1;
            right_c = (best_idx_next == LAST) ? '0 : best_idx_next + 1'b1;
            if (scan_last) begin
                iss_cnt_next  = '0;
                iss_done_next = 1'b0;
                any_next      = 1'b0;
                cnt_next      = '0;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next  = s_word;
                    out_next = '0;
                    rb_next  = 1'b0;
                    lr_next  = '0;
                    rr_next  = '0;
                    case (s_word.op)
                        OP_LOAD: begin
                            fit_we     = (32'(s_word.agent_index) < 32'(AGENTS));
                            state_next = ST_RESP;
                        end
                        OP_READ: begin
                            hist_re    = 1'b1;
                            state_next = ST_HREAD;
                        end
                        OP_STEP: state_next = ST_CHK;
                        default: state_next = ST_RESP;
                    endcase
                end
            end
            ST_HREAD: begin
                if (in_range && hvld_reg[in_addr]) begin
                    out_next.counter_value = 48'(hist_rdata);
                end
                state_next = ST_RESP;
            end
            ST_CHK: begin
                if (CMPW'(len_reg) < three_k) begin
                    rb_next      = 1'b1;
                    len_next     = '0;
                    rb_i_next    = '0;
                    key_idx_next = '0;
                    ret_next     = ST_POS;
                    state_next   = ST_KEY_RD;
                end else begin
                    state_next = ST_MIN;
                end
            end
            ST_KEY_RD: begin
                fit_re     = 1'b1;
                fit_raddr  = key_idx_reg;
                state_next = ST_KEY_WT;
            end
            ST_KEY_WT: begin
                key_fit_next = fit_rdata;
                state_next   = ret_reg;
            end
            // Rebuild: list the agent if fewer than 5k agents come before it
            ST_POS: begin
                if (scan_last) begin
                    pos_in = (CMPW'(cnt_fin) < five_k);
                    listed_next[rb_i_reg] = pos_in;
                    len_next = len_reg + LW'(pos_in);
                    if (rb_i_reg == LAST) begin
                        phase_next = PH_REBUILD;
                        state_next = ST_MAX;
                    end else begin
                        rb_i_next    = rb_i_reg + 1'b1;
                        key_idx_next = rb_i_reg + 1'b1;
                        ret_next     = ST_POS;
                        state_next   = ST_KEY_RD;
                    end
                end
            end
            ST_MIN: begin
                if (scan_last) begin
                    m_next     = best_idx_next;
                    left_next  = left_c;
                    right_next = right_c;
                    lflag_next = listed_reg[left_c];
                    rflag_next = listed_reg[right_c];
                    ret_next   = ST_RANK;
                    bsel_next  = 2'd0;
                    if (listed_reg[left_c]) begin
                        key_idx_next = left_c;
                        side_next    = 1'b0;
                        state_next   = ST_KEY_RD;
                    end else if (listed_reg[right_c]) begin
                        key_idx_next = right_c;
                        side_next    = 1'b1;
                        state_next   = ST_KEY_RD;
                    end else begin
                        state_next = ST_BUMP_RD;
                    end
                end
            end
            ST_RANK: begin
                if (scan_last) begin
                    if (!side_reg) begin
                        lr_next = cnt_fin;
                        if (rflag_reg) begin
                            key_idx_next = right_reg;
                            side_next    = 1'b1;
                            state_next   = ST_KEY_RD;
                        end else begin
                            state_next = ST_BUMP_RD;
                        end
                    end else begin
                        rr_next    = cnt_fin;
                        state_next = ST_BUMP_RD;
                    end
                end
            end
            // Histogram read-modify-write: rank 0, then listed neighbors
            ST_BUMP_RD: begin
                hist_re = 1'b1;
                case (bsel_reg)
                    2'd0:    hist_raddr = '0;
                    2'd1:    hist_raddr = lr_reg;
                    default: hist_raddr = rr_reg;
                endcase
                b_addr_next = hist_raddr;
                state_next  = ST_BUMP_WR;
            end
            ST_BUMP_WR: begin
                hist_we = 1'b1;
                hvld_next[b_addr_reg] = 1'b1;
                state_next = ST_BUMP_RD;
                if (bsel_reg == 2'd0 && lflag_reg) begin
                    bsel_next = 2'd1;
                end else if (bsel_reg != 2'd2 && rflag_reg) begin
                    bsel_next = 2'd2;
                end else begin
                    rep_sel_next = 2'd0;
                    state_next   = ST_REPL;
                end
            end
            ST_REPL: begin
                case (rep_sel_reg)
                    2'd0: begin
                        rep_agent = m_reg;
                        rep_value = in_reg.middle_value;
                    end
                    2'd1: begin
                        rep_agent = left_reg;
                        rep_value = in_reg.left_value;
                    end
                    default: begin
                        rep_agent = right_reg;
                        rep_value = in_reg.right_value;
                    end
                endcase
                fit_we    = 1'b1;
                fit_waddr = rep_agent;
                fit_wdata = rep_value;
                if (rep_value >= thr_reg) begin
                    if (listed_reg[rep_agent]) begin
                        listed_next[rep_agent] = 1'b0;
                        len_next = len_reg - 1'b1;
                    end
                end else if (!listed_reg[rep_agent]) begin
                    listed_next[rep_agent] = 1'b1;
                    len_next = len_reg + 1'b1;
                end
                phase_next = PH_REPLACE;
                state_next = ST_MAX;
            end
            // Largest listed agent: threshold, and trim candidate
            ST_MAX: begin
                if (scan_last) begin
                    if (any_reg || (listed_reg[d_idx_reg])) begin
                        thr_next = best_fit_next;
                    end
                    if (phase_reg == PH_REBUILD) begin
                        state_next = ST_MIN;
                    end else if (phase_reg == PH_REPLACE && rep_sel_reg != 2'd2) begin
                        rep_sel_next = rep_sel_reg + 1'b1;
                        state_next   = ST_REPL;
                    end else if (CMPW'(len_reg) > five_k
                                 && (any_reg || listed_reg[d_idx_reg])) begin
                        listed_next[best_idx_next] = 1'b0;
                        len_next   = len_reg - 1'b1;
                        phase_next = PH_TRIM;
                        state_next = ST_MAX;
                    end else begin
                        out_next.min_agent  = 7'(m_reg);
                        out_next.left_rank  = 7'(lr_reg);
                        out_next.right_rank = 7'(rr_reg);
                        out_next.rebuilt    = rb_reg;
                        out_next.list_count = 8'(len_reg);
                        state_next = ST_RESP;
                    end
                end
            end
            ST_RESP: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ret_reg      <= ST_IDLE;
            phase_reg    <= PH_REBUILD;
            rep_sel_reg  <= '0;
            bsel_reg     <= '0;
            side_reg     <= 1'b0;
            lflag_reg    <= 1'b0;
            rflag_reg    <= 1'b0;
            rb_reg       <= 1'b0;
            thr_reg      <= '0;
            len_reg      <= '0;
            listed_reg   <= '0;
            hvld_reg     <= '0;
            iss_cnt_reg  <= '0;
            iss_done_reg <= 1'b0;
            d_vld_reg    <= 1'b0;
            any_reg      <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            phase_reg    <= phase_next;
            rep_sel_reg  <= rep_sel_next;
            bsel_reg     <= bsel_next;
            side_reg     <= side_next;
            lflag_reg    <= lflag_next;
            rflag_reg    <= rflag_next;
            rb_reg       <= rb_next;
            thr_reg      <= thr_next;
            len_reg      <= len_next;
            listed_reg   <= listed_next;
            hvld_reg     <= hvld_next;
            iss_cnt_reg  <= iss_cnt_next;
            iss_done_reg <= iss_done_next;
            d_vld_reg    <= d_vld_next;
            any_reg      <= any_next;
            cnt_reg      <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        in_reg       <= in_next;
        out_reg      <= out_next;
        d_idx_reg    <= d_idx_next;
        best_fit_reg <= best_fit_next;
        best_idx_reg <= best_idx_next;
        key_fit_reg  <= key_fit_next;
        key_idx_reg  <= key_idx_next;
        m_reg        <= m_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        lr_reg       <= lr_next;
        rr_reg       <= rr_next;
        rb_i_reg     <= rb_i_next;
        b_addr_reg   <= b_addr_next;
    end

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import bss_pkg::*;

    localparam int N_AGENTS = 128;
    localparam logic [47:0] CNT_TOP = '1;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_word_t    s_word = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_word_t   m_word;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    bak_sneppen_shortlist_step dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_word(s_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_word(m_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow state of the engine
    logic [31:0] fit_mem [N_AGENTS];
    bit          on_list [N_AGENTS];
    logic [47:0] rank_cnt [N_AGENTS];
    logic [31:0] thr;
    int          list_len;
    int          kfac;

    out_word_t   pending_q [$];
    int          err_cnt = 0;
    int          words_sent = 0;
    int          steps_sent = 0;
    int          words_seen = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;

    function automatic bit ahead(int a, int b);
        return fit_mem[a] < fit_mem[b] || (fit_mem[a] == fit_mem[b] && a < b);
    endfunction

    function automatic void count_rank(int r);
        if (rank_cnt[r] != CNT_TOP) rank_cnt[r] = rank_cnt[r] + 1;
    endfunction

    function automatic int list_pos(int a);
        int r;
        r = 0;
        for (int i = 0; i < N_AGENTS; i++)
            if (on_list[i] && ahead(i, a)) r++;
        return r;
    endfunction

    function automatic void track_max();
        bit any;
        logic [31:0] mx;
        any = 0;
        mx = '0;
        for (int i = 0; i < N_AGENTS; i++)
            if (on_list[i] && (!any || fit_mem[i] > mx)) begin
                mx = fit_mem[i];
                any = 1;
            end
        if (any) thr = mx;
    endfunction

    function automatic void relist_smallest();
        int cap;
        int pos;
        cap = 5 * kfac;
        if (cap > N_AGENTS) cap = N_AGENTS;
        list_len = 0;
        for (int i = 0; i < N_AGENTS; i++) begin
            pos = 0;
            for (int j = 0; j < N_AGENTS; j++)
                if (ahead(j, i)) pos++;
            on_list[i] = pos < cap;
            if (on_list[i]) list_len++;
        end
        track_max();
    endfunction

    function automatic void set_fitness(int a, logic [31:0] v);
        fit_mem[a] = v;
        if (v >= thr) begin
            if (on_list[a]) begin
                on_list[a] = 0;
                list_len--;
            end
        end else if (!on_list[a]) begin
            on_list[a] = 1;
            list_len++;
        end
        track_max();
    endfunction

    function automatic out_word_t engine_result(in_word_t w);
        out_word_t o;
        int m, lft, rgt, lr, rr, top;
        bit any;
        o = '0;
        case (w.op)
            OP_LOAD: fit_mem[w.agent_index] = w.middle_value;
            OP_READ: o.counter_value = rank_cnt[w.agent_index];
            OP_STEP: begin
                if (list_len < 3 * kfac) begin
                    relist_smallest();
                    o.rebuilt = 1'b1;
                end
                m = 0;
                for (int i = 1; i < N_AGENTS; i++)
                    if (ahead(i, m)) m = i;
                lft = (m + N_AGENTS - 1) % N_AGENTS;
                rgt = (m + 1) % N_AGENTS;
                lr = 0;
                rr = 0;
                count_rank(0);
                if (on_list[lft]) begin
                    lr = list_pos(lft);
                    count_rank(lr);
                end
                if (on_list[rgt]) begin
                    rr = list_pos(rgt);
                    count_rank(rr);
                end
                set_fitness(m, w.middle_value);
                set_fitness(lft, w.left_value);
                set_fitness(rgt, w.right_value);
                while (list_len > 5 * kfac) begin
                    any = 0;
                    top = 0;
                    for (int i = 0; i < N_AGENTS; i++)
                        if (on_list[i] && (!any || ahead(top, i))) begin
                            top = i;
                            any = 1;
                        end
                    if (!any) break;
                    on_list[top] = 0;
                    list_len--;
                    track_max();
                end
                o.min_agent = m[6:0];
                o.left_rank = lr[6:0];
                o.right_rank = rr[6:0];
                o.list_count = list_len[7:0];
            end
            default: ;
        endcase
        return o;
    endfunction

    // sender: one word per call, valid held high across back-to-back words
    task automatic send_word(in_word_t w);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_q.push_back(engine_result(w));
        words_sent++;
        if (w.op == OP_STEP) steps_sent++;
    endtask

    task automatic sender_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        sender_idle();
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_list_factor(logic [4:0] k);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(REG_LIST_FACTOR) << 2;
        pwdata <= 32'(k);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        kfac = k;
    endtask

    function automatic in_word_t mk(logic [1:0] op, logic [6:0] idx,
                                    logic [31:0] mv, logic [31:0] lv, logic [31:0] rv);
        in_word_t w;
        w.op = op;
        w.agent_index = idx;
        w.middle_value = mv;
        w.left_value = lv;
        w.right_value = rv;
        return w;
    endfunction

    // new fitness: often below the current threshold so the list stays deep
    function automatic logic [31:0] fresh_value();
        case ($urandom_range(0, 3))
            0, 1: return $urandom_range(0, thr);
            2: return $urandom;
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    task automatic load_all_random();
        for (int i = 0; i < N_AGENTS; i++)
            send_word(mk(OP_LOAD, i[6:0], $urandom, $urandom, $urandom));
    endtask

    task automatic send_step();
        send_word(mk(OP_STEP, $urandom, fresh_value(), fresh_value(), fresh_value()));
    endtask

    // directed: field extremes, ties, ring wrap, every op
    task automatic test_directed();
        for (int i = 0; i < N_AGENTS; i++)
            send_word(mk(OP_LOAD, i[6:0], 32'h1000_0000 + i * 32'h0100_0000,
                         '1, '1));
        send_word(mk(OP_LOAD, 7'd0, 32'd0, '0, '0));
        send_word(mk(OP_LOAD, 7'd127, 32'hFFFF_FFFF, '1, '1));
        send_word(mk(OP_STEP, 7'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_word(mk(OP_STEP, 7'h7F, 32'd0, 32'd0, 32'd0));
        // minimum at the bottom of the ring (agent 0 wins the tie), left neighbour wraps
        send_word(mk(OP_LOAD, 7'd127, 32'd0, '0, '0));
        send_word(mk(OP_LOAD, 7'd0, 32'd0, '0, '0));
        send_word(mk(OP_STEP, 7'd0, 32'd5, 32'd5, 32'd5));
        send_word(mk(OP_STEP, 7'd0, 32'h8000_0000, 32'd1, 32'hFFFF_FFFE));
        send_word(mk(2'd3, 7'h55, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF));
        send_word(mk(OP_READ, 7'd0, '0, '0, '0));
        send_word(mk(OP_READ, 7'd127, '1, '1, '1));
        send_word(mk(OP_READ, 7'd1, '0, '0, '0));
        send_word(mk(OP_READ, 7'd2, '0, '0, '0));
        drain();
    endtask

    // random phase: optional reload, then steps mixed with reads, late loads and op 3
    task automatic test_random_phase(logic [4:0] k, int n_steps, bit reload);
        int pick;
        set_list_factor(k);
        if (reload) begin
            quiet = ($urandom_range(0, 2) == 0);
            load_all_random();
        end
        quiet = 1'b0;
        for (int i = 0; i < n_steps; i++) begin
            send_step();
            pick = $urandom_range(0, 9);
            if (pick < 3)
                send_word(mk(OP_READ, $urandom_range(0, 15), $urandom, $urandom, $urandom));
            else if (pick < 5)
                send_word(mk(OP_LOAD, $urandom, fresh_value(), $urandom, $urandom));
            else if (pick == 5)
                send_word(mk(2'd3, $urandom, $urandom, $urandom, $urandom));
            if ($urandom_range(0, 15) == 0) quiet = !quiet;
        end
        quiet = 1'b0;
        for (int r = 0; r < N_AGENTS; r += 9)
            send_word(mk(OP_READ, r[6:0], '0, '0, '0));
    endtask

    // receiver stalls for a long stretch while loads keep coming
    task automatic test_backpressure();
        quiet = 1'b1;
        hold_req <= 1'b1;
        @(posedge aclk);
        hold_req <= 1'b0;
        for (int i = 0; i < 24; i++)
            send_word(mk(OP_LOAD, $urandom, $urandom, $urandom, $urandom));
        quiet = 1'b0;
        drain();
    endtask

    // receiver ready, with random stalls per word
    int rx_gap = 0;
    int rx_hold = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req) begin
            rx_hold = 400;
            m_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            rx_gap = quiet ? 0 : $urandom_range(0, 12);
            m_ready <= (rx_gap == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        out_word_t exp_w;
        if (aresetn && m_valid && m_ready) begin
            words_seen++;
            if (pending_q.size() == 0) begin
                $error("result word with nothing expected");
                err_cnt++;
            end else begin
                exp_w = pending_q.pop_front();
                if (m_word.min_agent !== exp_w.min_agent) begin
                    $error("min_agent exp %0d got %0d", exp_w.min_agent, m_word.min_agent);
                    err_cnt++;
                end
                if (m_word.left_rank !== exp_w.left_rank) begin
                    $error("left_rank exp %0d got %0d", exp_w.left_rank, m_word.left_rank);
                    err_cnt++;
                end
                if (m_word.right_rank !== exp_w.right_rank) begin
                    $error("right_rank exp %0d got %0d", exp_w.right_rank, m_word.right_rank);
                    err_cnt++;
                end
                if (m_word.rebuilt !== exp_w.rebuilt) begin
                    $error("rebuilt exp %0d got %0d", exp_w.rebuilt, m_word.rebuilt);
                    err_cnt++;
                end
                if (m_word.list_count !== exp_w.list_count) begin
                    $error("list_count exp %0d got %0d", exp_w.list_count, m_word.list_count);
                    err_cnt++;
                end
                if (m_word.counter_value !== exp_w.counter_value) begin
                    $error("counter_value exp %0d got %0d",
                           exp_w.counter_value, m_word.counter_value);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        #200ms;
        $display("simulation failed");
        $finish;
    end

    initial begin
        for (int i = 0; i < N_AGENTS; i++) begin
            fit_mem[i] = '0;
            on_list[i] = 0;
            rank_cnt[i] = '0;
        end
        thr = '0;
        list_len = 0;
        kfac = LIST_FACTOR_RST;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_backpressure();
        test_random_phase(5'd5, 60, 1'b1);
        test_random_phase(5'd1, 12, 1'b0);
        test_random_phase(5'd25, 60, 1'b1);
        test_random_phase(5'd3, 40, 1'b0);
        test_random_phase(5'd0, 8, 1'b1);
        test_random_phase(5'd25, 20, 1'b0);
        test_backpressure();
        test_random_phase(5'd5, 40, 1'b1);

        drain();
        repeat (50) @(posedge aclk);
        if (pending_q.size() != 0) begin
            $error("%0d expected words never arrived", pending_q.size());
            err_cnt++;
        end
        $display("covered %0d words (%0d steps), %0d results checked",
                 words_sent, steps_sent, words_seen);
        $display("list factors 5, 1, 25, 3, 0; long receiver stalls; sender pauses");
        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
